@@ src/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 10;
    localparam int DATA_W  = 32;
    localparam int FOUND_W = 9;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_REMOVE = 3'd5,
        CMD_FIND   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_MISS   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET,
        S_POP,
        S_FILL,
        S_SET,
        S_INS,
        S_INS_PUT,
        S_REM_HEAD,
        S_REM_SHIFT,
        S_REM_ZERO,
        S_FIND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [FOUND_W-1:0] found_position;
        logic [COUNT_W-1:0] entry_count;
        status_t            status;
    } res_t;

endpackage

`default_nettype wire

@@ src/ple_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ple_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/ple_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_take,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [POS_W-1:0]       position,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        idle,
    output logic                        res_valid,
    input  wire logic                   res_take,
    output res_t                        res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [VALUE_WIDTH-1:0]      mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  wire logic [VALUE_WIDTH-1:0] mem_rdata
);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          hw_reg, hw_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] data_reg, data_next;
    logic [CW-1:0]          found_reg, found_next;
    status_t                stat_reg, stat_next;
    logic                   rd_live_reg;

    logic [31:0]            pos32, cnt32, hw32, idx32;
    logic [31:0]            pos_m1, cnt_m1, idx_m1, idx_m2, idx_p1, waddr_p1;
    logic [VALUE_WIDTH-1:0] rdv;
    logic                   pos_in, pos_ok_cap, full, beyond;
    logic [63:0]            data_ext;
    logic [31:0]            found32, cnt_out32;

    assign pos32    = 32'(pos_reg);
    assign cnt32    = 32'(cnt_reg);
    assign hw32     = 32'(hw_reg);
    assign idx32    = 32'(idx_reg);
    assign pos_m1   = pos32 - 32'd1;
    assign cnt_m1   = cnt32 - 32'd1;
    assign idx_m1   = idx32 - 32'd1;
    assign idx_m2   = idx32 - 32'd2;
    assign idx_p1   = idx32 + 32'd1;
    assign waddr_p1 = 32'(mem_waddr) + 32'd1;

    assign rdv        = rd_live_reg ? mem_rdata : '0;
    assign pos_in     = (pos32 != 32'd0) && (pos32 <= cnt32);
    assign pos_ok_cap = (pos32 != 32'd0) && (pos32 <= 32'(CAPACITY));
    assign full       = cnt32 >= 32'(CAPACITY);
    assign beyond     = pos32 > cnt32;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (cmd_reg)
                    CMD_PUSH:   state_next = S_DONE;
                    CMD_POP:    state_next = (cnt32 == 32'd0) ? S_DONE : S_POP;
                    CMD_GET:    state_next = pos_in ? S_GET : S_DONE;
                    CMD_SET,
                    CMD_INSERT:
                    begin
                        priority if (!pos_ok_cap)
                        begin
                            state_next = S_DONE;
                        end
                        else if (cmd_reg == CMD_SET || beyond)
                        begin
                            state_next = S_FILL;
                        end
                        else if (full)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    CMD_REMOVE: state_next = pos_in ? S_REM_HEAD : S_DONE;
                    CMD_FIND:
                    begin
                        state_next = (val_reg == '0 || cnt32 == 32'd0) ? S_DONE : S_FIND;
                    end
                    CMD_CLEAR:  state_next = S_DONE;
                endcase
            end
            S_FILL:      state_next = (hw32 < pos_m1) ? S_FILL : S_SET;
            S_SET:       state_next = S_DONE;
            S_GET:       state_next = S_DONE;
            S_POP:       state_next = S_DONE;
            S_INS:       state_next = (idx32 == pos32) ? S_INS_PUT : S_INS;
            S_INS_PUT:   state_next = S_DONE;
            S_REM_HEAD:  state_next = (pos32 == cnt32) ? S_REM_ZERO : S_REM_SHIFT;
            S_REM_SHIFT: state_next = (idx32 == cnt_m1) ? S_REM_ZERO : S_REM_SHIFT;
            S_REM_ZERO:  state_next = S_DONE;
            S_FIND:
            begin
                if (rdv == val_reg || idx32 == cnt_m1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_raddr  = idx_reg;
        cnt_next   = cnt_reg;
        hw_next    = hw_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        found_next = found_reg;
        stat_next  = stat_reg;
        unique case (state_reg)
            S_DECODE:
            begin
                data_next  = '0;
                found_next = '0;
                stat_next  = STAT_OK;
                unique case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cnt32[AW-1:0];
                            mem_wdata = val_reg;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (cnt32 == 32'd0)
                        begin
                            stat_next = STAT_MISS;
                        end
                        else
                        begin
                            mem_raddr = cnt_m1[AW-1:0];
                        end
                    end
                    CMD_GET:
                    begin
                        if (!pos_in)
                        begin
                            stat_next = STAT_BADPOS;
                        end
                        else
                        begin
                            mem_raddr = pos_m1[AW-1:0];
                        end
                    end
                    CMD_SET,
                    CMD_INSERT:
                    begin
                        priority if (!pos_ok_cap)
                        begin
                            stat_next = STAT_BADPOS;
                        end
                        else if (cmd_reg == CMD_SET || beyond)
                        begin
                            stat_next = STAT_OK;
                        end
                        else if (full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            idx_next  = cnt32[AW-1:0];
                            mem_raddr = cnt_m1[AW-1:0];
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!pos_in)
                        begin
                            stat_next = STAT_BADPOS;
                        end
                        else
                        begin
                            mem_raddr = pos_m1[AW-1:0];
                            idx_next  = pos32[AW-1:0];
                        end
                    end
                    CMD_FIND:
                    begin
                        stat_next = STAT_MISS;
                        idx_next  = '0;
                        mem_raddr = '0;
                    end
                    CMD_CLEAR:
                    begin
                        cnt_next = '0;
                        hw_next  = '0;
                    end
                endcase
            end
            S_FILL:
            begin
                if (hw32 < pos_m1)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = hw32[AW-1:0];
                end
                else
                begin
                    mem_raddr = pos_m1[AW-1:0];
                end
            end
            S_SET:
            begin
                data_next = rdv;
                mem_we    = 1'b1;
                mem_waddr = pos_m1[AW-1:0];
                mem_wdata = val_reg;
                if (beyond)
                begin
                    cnt_next = CW'(pos32);
                end
            end
            S_GET:
            begin
                data_next = rdv;
            end
            S_POP:
            begin
                data_next = rdv;
                mem_we    = 1'b1;
                mem_waddr = cnt_m1[AW-1:0];
                cnt_next  = cnt_reg - CW'(1);
            end
            S_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rdv;
                if (idx32 != pos32)
                begin
                    idx_next  = idx_m1[AW-1:0];
                    mem_raddr = idx_m2[AW-1:0];
                end
            end
            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_m1[AW-1:0];
                mem_wdata = val_reg;
                cnt_next  = cnt_reg + CW'(1);
            end
            S_REM_HEAD:
            begin
                data_next = rdv;
                mem_raddr = idx_reg;
            end
            S_REM_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_m1[AW-1:0];
                mem_wdata = rdv;
                if (idx32 != cnt_m1)
                begin
                    idx_next  = idx_p1[AW-1:0];
                    mem_raddr = idx_p1[AW-1:0];
                end
            end
            S_REM_ZERO:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m1[AW-1:0];
                cnt_next  = cnt_reg - CW'(1);
            end
            S_FIND:
            begin
                priority if (rdv == val_reg)
                begin
                    found_next = CW'(idx_p1);
                    stat_next  = STAT_OK;
                end
                else if (idx32 != cnt_m1)
                begin
                    idx_next  = idx_p1[AW-1:0];
                    mem_raddr = idx_p1[AW-1:0];
                end
                else
                begin
                    stat_next = STAT_MISS;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        if (mem_we && waddr_p1 > hw32)
        begin
            hw_next = CW'(waddr_p1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            hw_reg      <= '0;
            idx_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hw_reg      <= hw_next;
            idx_reg     <= idx_next;
            rd_live_reg <= 32'(mem_raddr) < hw32;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= cmd_t'(cmd);
            pos_reg <= position;
            val_reg <= value;
        end
        data_reg  <= data_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
    end

    assign data_ext  = 64'(data_reg);
    assign found32   = 32'(found_reg);
    assign cnt_out32 = 32'(cnt_reg);

    assign idle                = state_reg == S_IDLE;
    assign res_valid           = state_reg == S_DONE;
    assign res.data            = data_ext[DATA_W-1:0];
    assign res.found_position  = found32[FOUND_W-1:0];
    assign res.entry_count     = cnt_out32[COUNT_W-1:0];
    assign res.status          = stat_reg;

endmodule

`default_nettype wire

@@ src/positional_list_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY values, addressed by 1-based position, held in
// one synchronous memory with a write port and a registered read port. One
// command is taken at a time. Set first fills never written entries below its
// position, insert shifts the entries from its position up by one, remove
// shifts those after it down and zeroes the freed last slot, and find walks
// the entries to a match or the end, the memory port walking one entry per
// cycle. A high-water mark of written entries stands in for clearing the
// memory, so reset and clear are immediate with no clearing pass. The next
// command is accepted while the previous result waits in the output register.

module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic [DATA_W-1:0]  value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DATA_W-1:0]       data,
    output logic [FOUND_W-1:0]      found_position,
    output logic [COUNT_W-1:0]      entry_count,
    output logic [STAT_W-1:0]       status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                   in_take;
    logic                   ctrl_idle;
    logic                   res_valid;
    logic                   res_take;
    res_t                   res;
    res_t                   res_reg;
    logic                   out_valid_reg;
    logic [63:0]            value_ext;
    logic [VALUE_WIDTH-1:0] value_w;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    assign value_ext = 64'(value);
    assign value_w   = value_ext[VALUE_WIDTH-1:0];
    assign in_stall  = !ctrl_idle;
    assign in_take   = in_valid && !in_stall;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    ple_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .cmd       (cmd),
        .position  (position),
        .value     (value_w),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ple_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // hold the result item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign data           = res_reg.data;
    assign found_position = res_reg.found_position;
    assign entry_count    = res_reg.entry_count;
    assign status         = res_reg.status;

endmodule

`default_nettype wire

@@ tb/positional_list_engine_top_test.sv @@
`timescale 1ns / 1ps

module positional_list_engine_top_test;
    import ple_pkg::*;

    localparam int CAPACITY    = 256;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_ITEMS = 155;
    localparam int HOLDOFF     = 600;
    localparam int CYCLE_LIMIT = 2000000;

    class list_mirror;
        logic [DATA_W-1:0] entries [CAPACITY];
        int unsigned       fill;
        res_t              awaited [$];
        int unsigned       mismatches;

        function new();
            foreach (entries[i])
                entries[i] = '0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void apply_command(cmd_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
            res_t        r;
            int unsigned p;
            r        = '0;
            r.status = STAT_OK;
            p        = pos;
            case (op)
                CMD_PUSH:
                    if (fill >= CAPACITY)
                        r.status = STAT_FULL;
                    else
                    begin
                        entries[fill] = val;
                        fill++;
                    end
                CMD_POP:
                    if (fill == 0)
                        r.status = STAT_MISS;
                    else
                    begin
                        r.data            = entries[fill - 1];
                        entries[fill - 1] = '0;
                        fill--;
                    end
                CMD_GET:
                    if (p == 0 || p > fill)
                        r.status = STAT_BADPOS;
                    else
                        r.data = entries[p - 1];
                CMD_SET, CMD_INSERT:
                    if (p == 0 || p > CAPACITY)
                        r.status = STAT_BADPOS;
                    else if (op == CMD_SET || p > fill)
                    begin
                        r.data         = entries[p - 1];
                        entries[p - 1] = val;
                        if (p > fill)
                            fill = p;
                    end
                    else if (fill >= CAPACITY)
                        r.status = STAT_FULL;
                    else
                    begin
                        for (int i = fill; i >= int'(p); i--)
                            entries[i] = entries[i - 1];
                        entries[p - 1] = val;
                        fill++;
                    end
                CMD_REMOVE:
                    if (p == 0 || p > fill)
                        r.status = STAT_BADPOS;
                    else
                    begin
                        r.data = entries[p - 1];
                        for (int i = p; i < int'(fill); i++)
                            entries[i - 1] = entries[i];
                        entries[fill - 1] = '0;
                        fill--;
                    end
                CMD_FIND:
                begin
                    r.status = STAT_MISS;
                    if (val != '0)
                        for (int i = 0; i < int'(fill); i++)
                            if (entries[i] == val)
                            begin
                                r.found_position = FOUND_W'(i + 1);
                                r.status         = STAT_OK;
                                break;
                            end
                end
                default:
                begin
                    foreach (entries[i])
                        entries[i] = '0;
                    fill = 0;
                end
            endcase
            r.entry_count = COUNT_W'(fill);
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [DATA_W-1:0] d, logic [FOUND_W-1:0] f,
                                  logic [COUNT_W-1:0] c, logic [STAT_W-1:0] s);
            res_t e;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h found %0d count %0d status %0d",
                             d, f, c, s);
                return;
            end
            e = awaited.pop_front();
            if (e.data !== d || e.found_position !== f || e.entry_count !== c
                || e.status !== status_t'(s))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected data %h found %0d count %0d status %0d, got data %h found %0d count %0d status %0d",
                             e.data, e.found_position, e.entry_count, e.status, d, f, c, s);
            end
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd        = '0;
    logic [POS_W-1:0]   position   = '0;
    logic [DATA_W-1:0]  value      = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [DATA_W-1:0]  data;
    logic [FOUND_W-1:0] found_position;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  status;

    list_mirror         mirror;
    logic [DATA_W-1:0]  value_pool [POOL_SIZE];
    bit                 steady      = 1'b0;
    bit                 holdoff_req = 1'b0;
    int unsigned        cycle_count = 0;

    positional_list_engine_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data           (data),
        .found_position (found_position),
        .entry_count    (entry_count),
        .status         (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                mirror.check_reply(data, found_position, entry_count, status);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLDOFF) @(posedge clk);
            end
            out_stall <= !steady && $urandom_range(99) < 37;
        end
    end

    task automatic send_command(input cmd_t op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        while (!steady && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        mirror.apply_command(op, pos, val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 30)
            return $urandom;
        return value_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [POS_W-1:0] pick_position(cmd_t op, int unsigned fill);
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(99);
        top  = (op == CMD_INSERT) ? fill + 1 : fill;
        if (roll < 3)
            return '0;
        if (roll < 5)
            return POS_W'($urandom_range(1023));
        if (roll < 7)
            return POS_W'($urandom_range(1023, CAPACITY + 1));
        if (roll < 12 || top == 0)
            return POS_W'($urandom_range((fill + 8 > CAPACITY) ? CAPACITY : fill + 8, fill + 1));
        return POS_W'($urandom_range(top, 1));
    endfunction

    task automatic random_command(input int unsigned ceiling);
        int unsigned roll;
        int unsigned fill;
        cmd_t        op;
        roll = $urandom_range(99);
        fill = mirror.fill;
        if (roll < 22)
            op = (fill >= ceiling) ? CMD_POP : CMD_PUSH;
        else if (roll < 34)
            op = CMD_POP;
        else if (roll < 46)
            op = CMD_GET;
        else if (roll < 56)
            op = CMD_SET;
        else if (roll < 68)
            op = (fill >= ceiling) ? CMD_REMOVE : CMD_INSERT;
        else if (roll < 80)
            op = CMD_REMOVE;
        else if (roll < 97)
            op = CMD_FIND;
        else
            op = CMD_CLEAR;
        send_command(op, pick_position(op, fill), pick_value());
    endtask

    initial
    begin
        int unsigned ceilings [10];
        mirror   = new();
        ceilings = '{4, 16, 32, 16, CAPACITY, 8, 64, 16, 2, 16};
        value_pool[0] = '1;
        value_pool[1] = 32'h0000_0001;
        value_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            value_pool[i] = $urandom | 32'h0000_0100;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_POP,    10'd0,    32'h0);
        send_command(CMD_GET,    10'd1,    32'h0);
        send_command(CMD_REMOVE, 10'd1,    32'h0);
        send_command(CMD_FIND,   10'd0,    32'h0);
        send_command(CMD_FIND,   10'd0,    32'hFFFF_FFFF);
        send_command(CMD_PUSH,   10'd0,    32'hFFFF_FFFF);
        send_command(CMD_PUSH,   10'd1023, 32'h0);
        send_command(CMD_PUSH,   10'd0,    32'h0000_0001);
        send_command(CMD_INSERT, 10'd1,    32'hA5A5_A5A5);
        send_command(CMD_INSERT, 10'd5,    32'h8000_0000);
        send_command(CMD_GET,    10'd0,    32'h0);
        send_command(CMD_GET,    10'd1023, 32'h0);
        send_command(CMD_FIND,   10'd0,    32'h0000_0001);
        send_command(CMD_FIND,   10'd0,    32'h0);
        send_command(CMD_REMOVE, 10'd2,    32'h0);
        send_command(CMD_SET,    10'd0,    32'h1234_5678);
        send_command(CMD_SET,    10'd257,  32'h1234_5678);
        send_command(CMD_INSERT, 10'd1023, 32'h1234_5678);
        send_command(CMD_INSERT, 10'd0,    32'h1234_5678);
        send_command(CMD_SET,    10'd10,   32'h5A5A_5A5A);
        send_command(CMD_GET,    10'd7,    32'h0);
        send_command(CMD_SET,    10'd256,  32'h0000_FFFF);
        send_command(CMD_PUSH,   10'd0,    32'h7777_7777);
        send_command(CMD_INSERT, 10'd3,    32'h7777_7777);
        send_command(CMD_POP,    10'd0,    32'h0);
        send_command(CMD_CLEAR,  10'd0,    32'h0);
        wait_drained();

        foreach (ceilings[ph])
        begin
            steady = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == 40)
                    holdoff_req = 1'b1;
                random_command(ceilings[ph]);
            end
            wait_drained();
        end
        steady = 1'b0;

        repeat (300) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ positional_list_engine_top.f @@
src/ple_pkg.sv
src/ple_mem.sv
src/ple_ctrl.sv
src/positional_list_engine_top.sv
tb/positional_list_engine_top_test.sv
